// ----- sv/tmce_pkg.sv -----
// tmce_pkg: shared types and constants for the text mode console engine
// opcodes, character codes, field widths and the controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package tmce_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // character codes handled by put
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

  // attribute after reset
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // latch a new transaction, issue its read
    logic exec;       // carry out the latched operation
    logic fill;       // write one blank cell at the sweep pointer
    logic fill_init;  // blank with the reset attribute
    logic scroll_rd;  // read the cell one row below the pointer
    logic scroll_wr;  // write that cell at the pointer
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_fill;    // latched operation clears the screen
    logic need_scroll;  // put moves past the last row
    logic fill_last;    // pointer at the last cell
    logic scroll_last;  // pointer at the last cell that gets copied
  } status_t;

endpackage

// ----- sv/tmce_ctrl.sv -----
// tmce_ctrl: sequencer for the text mode console engine
// steps the datapath through reset clear, operations, scroll and fill sweeps
// depends on tmce_pkg
`timescale 1ns / 1ps

module tmce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output tmce_pkg::cmd_t   cmd,
  input  tmce_pkg::status_t status
);
  import tmce_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_FILL
  } state_t;

  state_t state;

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      // strobe registered from the last state of a transaction
      done <= ((state == S_EXEC) && !status.need_fill && !status.need_scroll) ||
              ((state == S_FILL) && status.fill_last);
      case (state)
        S_INIT: begin
          if (status.fill_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          if (status.need_fill) begin
            state <= S_FILL;
          end else if (status.need_scroll) begin
            state <= S_SCROLL_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCROLL_RD: begin
          state <= S_SCROLL_WR;
        end
        S_SCROLL_WR: begin
          if (status.scroll_last) state <= S_FILL;
          else state <= S_SCROLL_RD;
        end
        S_FILL: begin
          if (status.fill_last) state <= S_IDLE;
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == S_IDLE) && start;
    cmd.exec      = (state == S_EXEC);
    cmd.fill      = (state == S_FILL) || (state == S_INIT);
    cmd.fill_init = (state == S_INIT);
    cmd.scroll_rd = (state == S_SCROLL_RD);
    cmd.scroll_wr = (state == S_SCROLL_WR);
  end

  assign busy = (state != S_IDLE);

  // a result only appears once the engine is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transaction makes the engine busy, with no result yet, in the cycle after acceptance
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not occupy the engine");

  // no two results back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

// ----- sv/tmce_datapath.sv -----
// tmce_datapath: screen store, cursor, attribute and result registers
// executes the commands of tmce_ctrl; one read and one write port on the store
// depends on tmce_pkg
`timescale 1ns / 1ps

module tmce_datapath #(
  parameter int COLUMNS = tmce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmce_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tmce_pkg::cmd_t                cmd,
  output tmce_pkg::status_t             status,
  input  logic                          cfg_write,
  input  logic [tmce_pkg::ATTR_W-1:0]   cfg_data,
  input  logic [tmce_pkg::OP_W-1:0]     opcode,
  input  logic [tmce_pkg::CHAR_W-1:0]   char_code,
  input  logic [tmce_pkg::COL_W-1:0]    new_column,
  input  logic [tmce_pkg::ROW_W-1:0]    new_row,
  input  logic [tmce_pkg::IDX_W-1:0]    cell_index,
  output logic [tmce_pkg::LOC_W-1:0]    cursor_location,
  output logic [tmce_pkg::CELL_W-1:0]   cell_data
);
  import tmce_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  // screen store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  // control and latched transaction
  logic [ATTR_W-1:0] attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] ptr;
  opcode_t           op;
  logic [CHAR_W-1:0] ch;
  logic [COL_W-1:0]  set_col;
  logic [ROW_W-1:0]  set_row;
  logic              idx_ok;

  // put decode
  logic [COL_W:0]    put_col;
  logic [ROW_W-1:0]  put_row;
  logic              put_we;
  logic [COL_W-1:0]  put_wcol;
  logic [CHAR_W-1:0] put_char;
  logic              put_scroll;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [LOC_W-1:0]  loc_next;
  logic [CELL_W-1:0] data_next;
  logic [CELL_W-1:0] blank;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) attr <= RESET_ATTR;
    else if (cfg_write) attr <= cfg_data;
  end

  // latch transaction fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= opcode_t'(opcode);
      ch      <= char_code;
      set_col <= new_column;
      set_row <= new_row;
      idx_ok  <= (int'(cell_index) < CELLS);
    end
  end

  // put byte: cursor motion and cell write
  always_comb begin
    put_col    = {1'b0, col};
    put_row    = row;
    put_we     = 1'b0;
    put_wcol   = col;
    put_char   = CH_SPACE;
    if (ch == CH_BS && col != '0) begin
      put_col  = {1'b0, col} - 1'b1;
      put_wcol = col - 1'b1;
      put_we   = 1'b1;
    end else if (ch == CH_TAB) begin
      put_col = ({1'b0, col} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
    end else if (ch == CH_CR) begin
      put_col = '0;
    end else if (ch == CH_LF) begin
      put_col = '0;
      put_row = row + 1'b1;
    end else if (ch >= CH_SPACE && ch <= CH_PRINT_MAX) begin
      put_char = ch;
      put_we   = 1'b1;
      put_col  = {1'b0, col} + 1'b1;
    end
    // wrap past the last column
    if (int'(put_col) >= COLUMNS) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll = (int'(put_row) >= ROWS);
    if (put_scroll) put_row = ROW_W'(ROWS - 1);
  end

  // cursor after the operation and result values
  always_comb begin
    col_next = col;
    row_next = row;
    case (op)
      OP_PUT: begin
        col_next = put_col[COL_W-1:0];
        row_next = put_row;
      end
      OP_SET: begin
        col_next = (int'(set_col) >= COLUMNS) ? COL_W'(COLUMNS - 1) : set_col;
        row_next = (int'(set_row) >= ROWS) ? ROW_W'(ROWS - 1) : set_row;
      end
      default: begin
        col_next = col;
        row_next = row;
      end
    endcase
    loc_next  = LOC_W'(int'(row_next) * COLUMNS + int'(col_next));
    data_next = (op == OP_READ && idx_ok) ? rdata : '0;
  end

  // cursor, sweep pointer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ptr <= '0;
    end else begin
      if (cmd.exec) begin
        col <= col_next;
        row <= row_next;
        ptr <= '0;
      end else if (cmd.fill || cmd.scroll_wr) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cursor_location <= loc_next;
      cell_data       <= data_next;
    end
  end

  // store port selection
  assign blank = cmd.fill_init ? {RESET_ATTR, CH_SPACE} : {attr, CH_SPACE};
  assign raddr = cmd.accept ? ADDR_W'(cell_index) : ADDR_W'(int'(ptr) + COLUMNS);

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = blank;
    if (cmd.exec && op == OP_PUT && put_we) begin
      we    = 1'b1;
      waddr = ADDR_W'(int'(row) * COLUMNS + int'(put_wcol));
      wdata = {attr, put_char};
    end else if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.scroll_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.accept || cmd.scroll_rd) rdata <= mem[raddr];
  end

  // status to the controller
  always_comb begin
    status             = '0;
    status.need_fill   = (op == OP_CLEAR);
    status.need_scroll = (op == OP_PUT) && put_scroll;
    status.fill_last   = (ptr == ADDR_W'(CELLS - 1));
    status.scroll_last = (ptr == ADDR_W'(CELLS - COLUMNS - 1));
  end

  // cursor always stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(col) < COLUMNS) && (int'(row) < ROWS))
    else $error("cursor left the screen");

  // store writes stay inside the store
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (int'(waddr) < CELLS))
    else $error("store write out of range");

endmodule

// ----- sv/text_mode_console_engine.sv -----
// text_mode_console_engine: character terminal with a cell store and a cursor
// channel      | signals                                              | direction
// command      | start, busy, opcode, char_code, new_column, new_row, | in
//              | cell_index                                           |
// result       | done, cursor_location, cell_data                     | out
// config       | cfg_write, cfg_data (text attribute)                 | in
// put, set cursor and read cell go from start to done through a store write
// or registered store read, then the result register
// a put that scrolls copies each cell up a row through the read and write
// ports, a read state and a write state per cell, then blanks the bottom row
// clear blanks one cell per cycle through the write port
// after reset busy stays high while the store is blanked
// done is a one-cycle strobe; the receiver cannot stall it
// depends on tmce_pkg, tmce_ctrl, tmce_datapath
`timescale 1ns / 1ps

module text_mode_console_engine #(
  parameter int COLUMNS = tmce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmce_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tmce_pkg::OP_W-1:0]     opcode,
  input  logic [tmce_pkg::CHAR_W-1:0]   char_code,
  input  logic [tmce_pkg::COL_W-1:0]    new_column,
  input  logic [tmce_pkg::ROW_W-1:0]    new_row,
  input  logic [tmce_pkg::IDX_W-1:0]    cell_index,
  output logic                          done,
  output logic [tmce_pkg::LOC_W-1:0]    cursor_location,
  output logic [tmce_pkg::CELL_W-1:0]   cell_data,
  input  logic                          cfg_write,
  input  logic [tmce_pkg::ATTR_W-1:0]   cfg_data
);
  import tmce_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  tmce_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  // store, cursor and results
  tmce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .char_code       (char_code),
    .new_column      (new_column),
    .new_row         (new_row),
    .cell_index      (cell_index),
    .cursor_location (cursor_location),
    .cell_data       (cell_data)
  );

endmodule

// ----- tb/text_mode_console_engine_tb.sv -----
// text_mode_console_engine_tb: self-checking bench for the text mode console engine
// keeps a shadow screen and cursor, predicts every reply and checks it against done
// depends on tmce_pkg and text_mode_console_engine
`timescale 1ns / 1ps

module text_mode_console_engine_tb;
  import tmce_pkg::*;

  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;

  // random part: attribute phases, useful commands per phase, slow operations per phase
  localparam int PHASES            = 6;
  localparam int PHASE_ITEMS       = 285;
  localparam int SCROLLS_PER_PHASE = 12;
  localparam int CLEARS_PER_PHASE  = 4;

  // the slowest correct run is dominated by scrolls and clears
  localparam longint LIMIT_NS = 64'd8_000_000;

  typedef struct {
    logic [LOC_W-1:0]  loc;
    logic [CELL_W-1:0] data;
  } console_reply_t;

  // shadow copy of the screen, cursor and attribute, plus the replies still due
  class screen_shadow;
    logic [CELL_W-1:0] cells [CELLS];
    int                col;
    int                row;
    logic [ATTR_W-1:0] attr;
    console_reply_t    due_replies [$];
    int                mismatches;
    int                replies_seen;
    int                commands_seen;
    int                scrolls;
    int                clears;

    function new();
      attr          = RESET_ATTR;
      col           = 0;
      row           = 0;
      mismatches    = 0;
      replies_seen  = 0;
      commands_seen = 0;
      scrolls       = 0;
      clears        = 0;
      blank_all();
    endfunction

    function logic [CELL_W-1:0] blank();
      return {attr, CH_SPACE};
    endfunction

    function void blank_all();
      foreach (cells[i]) cells[i] = blank();
    endfunction

    function int location();
      return row * COLS + col;
    endfunction

    // cursor motion of one put byte; returns the cell written, or -1
    function int put_motion(input logic [CHAR_W-1:0] ch, inout int c, inout int r,
                            output logic [CHAR_W-1:0] wch);
      int wr;
      wr  = -1;
      wch = ch;
      if (ch == CH_BS && c != 0) begin
        c   = c - 1;
        wr  = r * COLS + c;
        wch = CH_SPACE;
      end else if (ch == CH_TAB) begin
        c = (c + 8) & ~7;
      end else if (ch == CH_CR) begin
        c = 0;
      end else if (ch == CH_LF) begin
        c = 0;
        r = r + 1;
      end else if (ch >= CH_SPACE && ch <= CH_PRINT_MAX) begin
        wr = r * COLS + c;
        c  = c + 1;
      end
      // wrap past the last column
      if (c >= COLS) begin
        c = 0;
        r = r + 1;
      end
      return wr;
    endfunction

    function bit put_scrolls(logic [CHAR_W-1:0] ch);
      int                c;
      int                r;
      logic [CHAR_W-1:0] w;
      c = col;
      r = row;
      void'(put_motion(ch, c, r, w));
      return r >= ROWS;
    endfunction

    function bit put_ignored(logic [CHAR_W-1:0] ch);
      return !((ch == CH_BS && col != 0) || ch == CH_TAB || ch == CH_CR || ch == CH_LF ||
               (ch >= CH_SPACE && ch <= CH_PRINT_MAX));
    endfunction

    // apply one accepted transaction and queue the reply it must produce
    function void log_command(opcode_t op, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] nc,
                              logic [ROW_W-1:0] nr, logic [IDX_W-1:0] idx);
      console_reply_t    rep;
      int                wr;
      logic [CHAR_W-1:0] wch;
      rep.data = '0;
      commands_seen++;
      case (op)
        OP_PUT: begin
          wr = put_motion(ch, col, row, wch);
          if (wr >= 0) cells[wr] = {attr, wch};
          // scroll up one row, blank the bottom row
          if (row >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = blank();
            row = ROWS - 1;
            scrolls++;
          end
        end
        OP_SET: begin
          col = (nc >= COLS) ? COLS - 1 : int'(nc);
          row = (nr >= ROWS) ? ROWS - 1 : int'(nr);
        end
        OP_CLEAR: begin
          blank_all();
          clears++;
        end
        default: begin
          if (idx < CELLS) rep.data = cells[idx];
        end
      endcase
      rep.loc = LOC_W'(location());
      due_replies.push_back(rep);
    endfunction

    task check_reply(logic [LOC_W-1:0] loc, logic [CELL_W-1:0] data);
      console_reply_t want;
      if (due_replies.size() == 0) begin
        flag($sformatf("reply with none due: loc=%0d data=%h", loc, data));
        return;
      end
      want = due_replies.pop_front();
      replies_seen++;
      if (loc !== want.loc)
        flag($sformatf("reply %0d cursor_location %0d, want %0d", replies_seen, loc, want.loc));
      if (data !== want.data)
        flag($sformatf("reply %0d cell_data %h, want %h", replies_seen, data, want.data));
    endtask

    task flag(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     opcode = '0;
  logic [CHAR_W-1:0]   char_code = '0;
  logic [COL_W-1:0]    new_column = '0;
  logic [ROW_W-1:0]    new_row = '0;
  logic [IDX_W-1:0]    cell_index = '0;
  logic                done;
  logic [LOC_W-1:0]    cursor_location;
  logic [CELL_W-1:0]   cell_data;
  logic                cfg_write = 1'b0;
  logic [ATTR_W-1:0]   cfg_data = '0;

  screen_shadow sb;
  int           scrolls_left;
  int           clears_left;
  int           attr_writes;

  text_mode_console_engine #(
    .COLUMNS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .char_code(char_code),
    .new_column(new_column),
    .new_row(new_row),
    .cell_index(cell_index),
    .done(done),
    .cursor_location(cursor_location),
    .cell_data(cell_data),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_reply(cursor_location, cell_data);
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d replies still due", sb.due_replies.size());
    $display("CHECK FAILED");
    $finish;
  end

  // one transaction: optional idle burst, then raise start and wait until busy is low
  task automatic send_item(opcode_t op, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] nc,
                           logic [ROW_W-1:0] nr, logic [IDX_W-1:0] idx, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    start      = 1'b1;
    opcode     = op;
    char_code  = ch;
    new_column = nc;
    new_row    = nr;
    cell_index = idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.log_command(op, ch, nc, nr, idx);
  endtask

  // stop issuing and wait until the block is quiet
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.due_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] a);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = a;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.attr   = a;
    attr_writes++;
  endtask

  // edge cases of every operation under the reset attribute
  task automatic directed();
    send_item(OP_READ, 8'h00, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1999, 1'b1);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0, 11'h7FF, 1'b1);
    send_item(OP_PUT, 8'h41, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, CH_SPACE, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, CH_PRINT_MAX, 7'd0, 5'd0, 11'd0, 1'b1);
    // ignored bytes
    send_item(OP_PUT, 8'h00, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, 8'h1F, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, 8'h80, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, 8'hFF, 7'd0, 5'd0, 11'd0, 1'b1);
    // backspace blanks the previous cell
    send_item(OP_PUT, CH_BS, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0, 11'd2, 1'b1);
    send_item(OP_PUT, CH_TAB, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, CH_CR, 7'd0, 5'd0, 11'd0, 1'b1);
    // backspace at column zero does nothing
    send_item(OP_PUT, CH_BS, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, CH_LF, 7'd0, 5'd0, 11'd0, 1'b1);
    // set cursor saturates, last cell then wraps and scrolls
    send_item(OP_SET, 8'h00, 7'd127, 5'd31, 11'd0, 1'b1);
    send_item(OP_PUT, 8'h5A, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1919, 1'b1);
    // tab from the last column wraps
    send_item(OP_SET, 8'h00, 7'd79, 5'd0, 11'd0, 1'b1);
    send_item(OP_PUT, CH_TAB, 7'd0, 5'd0, 11'd0, 1'b1);
    // line feed on the bottom row scrolls
    send_item(OP_SET, 8'h00, 7'd0, 5'd24, 11'd0, 1'b1);
    send_item(OP_PUT, CH_LF, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_CLEAR, 8'h00, 7'd0, 5'd0, 11'd0, 1'b1);
    send_item(OP_READ, 8'h00, 7'd0, 5'd0, 11'd1919, 1'b1);
  endtask

  // one random transaction; counted is low for a put that the block ignores
  task automatic random_item(input bit gaps, output bit counted);
    int                pick;
    int                t;
    opcode_t           op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  nc;
    logic [ROW_W-1:0]  nr;
    logic [IDX_W-1:0]  idx;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    nc   = COL_W'($urandom_range(0, 127));
    nr   = ROW_W'($urandom_range(0, 31));
    idx  = IDX_W'($urandom_range(0, 2047));
    if (pick < 55) begin
      op = OP_PUT;
      t  = $urandom_range(0, 99);
      if (t < 55)      ch = CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_MAX));
      else if (t < 63) ch = CH_BS;
      else if (t < 70) ch = CH_TAB;
      else if (t < 76) ch = CH_CR;
      else if (t < 82) ch = CH_LF;
    end else if (pick < 70) begin
      op = OP_SET;
      if ($urandom_range(0, 3) != 0) nr = ROW_W'($urandom_range(0, ROWS - 1));
    end else if (pick < 98 || clears_left == 0) begin
      op = OP_READ;
      t  = $urandom_range(0, 9);
      if (t < 5) begin
        // just behind the cursor, where cells were written
        t = sb.location() - int'($urandom_range(1, 3));
        if (t < 0) t = 0;
        idx = IDX_W'(t);
      end else if (t < 9) begin
        idx = IDX_W'($urandom_range(0, CELLS - 1));
      end
    end else begin
      op = OP_CLEAR;
      clears_left--;
    end
    // scrolls are slow: out of budget, move the cursor off the bottom instead
    if (op == OP_PUT && sb.put_scrolls(ch)) begin
      if (scrolls_left == 0) begin
        op = OP_SET;
        nr = ROW_W'($urandom_range(0, ROWS - 2));
      end else begin
        scrolls_left--;
      end
    end
    counted = !(op == OP_PUT && sb.put_ignored(ch));
    send_item(op, ch, nc, nr, idx, gaps);
  endtask

  // main sequence
  initial begin
    logic [ATTR_W-1:0] a;
    bit                counted;
    int                useful;
    sb          = new();
    attr_writes = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed();

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       a = 8'h00;
        1:       a = 8'hFF;
        default: a = ATTR_W'($urandom_range(0, 255));
      endcase
      write_attr(a);
      scrolls_left = SCROLLS_PER_PHASE;
      clears_left  = CLEARS_PER_PHASE;
      useful       = 0;
      // no idling in the last phase
      while (useful < PHASE_ITEMS) begin
        random_item(p != PHASES - 1, counted);
        if (counted) useful++;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.due_replies.size() != 0)
      sb.flag($sformatf("%0d replies never arrived", sb.due_replies.size()));

    $display("covered %0d transactions, %0d replies checked, %0d scrolls, %0d clears",
             sb.commands_seen, sb.replies_seen, sb.scrolls, sb.clears);
    $display("attribute written %0d times including 0x00 and 0xff, %0d mismatches",
             attr_writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
